>>> rtl/core/mmhq_pkg.sv
package mmhq_pkg;

    // Default number of entries the queue can hold.
    localparam int CAPACITY_DEF = 512;

    // Request kinds.
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_RM_MIN = 2'd1;
    localparam logic [1:0] KIND_RM_MAX = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // One heap entry; the packed order is also the sort key.
    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] burst;
        logic [15:0] id;
    } t_entry;

    // Micro-operations issued by the controller to the datapath.
    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_DISP,
        CMD_RD_PARENT,
        CMD_UP_CMP,
        CMD_RD_GP,
        CMD_BU_CMP,
        CMD_PUT,
        CMD_RD_TOP0,
        CMD_CAP0,
        CMD_CAP1,
        CMD_CAP2,
        CMD_RM_SEL,
        CMD_RD_LAST,
        CMD_LD_X,
        CMD_TD_INIT,
        CMD_SCAN,
        CMD_TD_DEC,
        CMD_TD_PCMP,
        CMD_FIN
    } t_cmd;

    // Datapath status seen by the controller.
    typedef struct packed {
        logic [1:0] kind;
        logic       empty;
        logic       full;
        logic       i_zero;
        logic       i_lt3;
        logic       leaf;
        logic       better;
        logic       m_child;
        logic       s_inner;
        logic       scan_done;
        logic       out_busy;
    } t_sts;

    // True when a ranks before b on a min level (is_min) or a max level.
    function automatic logic better(input t_entry a, input t_entry b, input logic is_min);
        return is_min ? (a < b) : (a > b);
    endfunction

endpackage

>>> rtl/core/mmhq_ctrl.sv
module mmhq_ctrl
    import mmhq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [23:0] {
        S_IDLE     = 24'h000001,
        S_DISP     = 24'h000002,
        S_UP_RD    = 24'h000004,
        S_UP_CMP   = 24'h000008,
        S_BU_RD    = 24'h000010,
        S_BU_CMP   = 24'h000020,
        S_PUT      = 24'h000040,
        S_R0       = 24'h000080,
        S_R1       = 24'h000100,
        S_R2       = 24'h000200,
        S_R3       = 24'h000400,
        S_RM_SEL   = 24'h000800,
        S_RM_RDL   = 24'h001000,
        S_RM_LX    = 24'h002000,
        S_TD_START = 24'h004000,
        S_SCAN     = 24'h008000,
        S_TD_DEC   = 24'h010000,
        S_TD_RDP   = 24'h020000,
        S_TD_PCMP  = 24'h040000,
        S_F0       = 24'h080000,
        S_F1       = 24'h100000,
        S_F2       = 24'h200000,
        S_F3       = 24'h400000,
        S_FIN      = 24'h800000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = (r_state == S_IDLE);

    // Sequencing of the heap operations.
    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd = CMD_DISP;
                if (i_sts.kind == KIND_INSERT) begin
                    n_state = i_sts.full ? S_F0 : S_UP_RD;
                end else if (i_sts.kind == KIND_RM_MIN || i_sts.kind == KIND_RM_MAX) begin
                    n_state = i_sts.empty ? S_F0 : S_R0;
                end else begin
                    n_state = S_F0;
                end
            end
            S_UP_RD: begin
                if (i_sts.i_zero) begin
                    n_state = S_PUT;
                end else begin
                    o_cmd   = CMD_RD_PARENT;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                o_cmd   = CMD_UP_CMP;
                n_state = S_BU_RD;
            end
            S_BU_RD: begin
                if (i_sts.i_lt3) begin
                    n_state = S_PUT;
                end else begin
                    o_cmd   = CMD_RD_GP;
                    n_state = S_BU_CMP;
                end
            end
            S_BU_CMP: begin
                o_cmd   = CMD_BU_CMP;
                n_state = i_sts.better ? S_BU_RD : S_PUT;
            end
            S_PUT: begin
                o_cmd   = CMD_PUT;
                n_state = S_F0;
            end
            S_R0: begin
                o_cmd   = CMD_RD_TOP0;
                n_state = S_R1;
            end
            S_R1: begin
                o_cmd   = CMD_CAP0;
                n_state = S_R2;
            end
            S_R2: begin
                o_cmd   = CMD_CAP1;
                n_state = S_R3;
            end
            S_R3: begin
                o_cmd   = CMD_CAP2;
                n_state = S_RM_SEL;
            end
            S_RM_SEL: begin
                o_cmd   = CMD_RM_SEL;
                n_state = i_sts.s_inner ? S_RM_RDL : S_F0;
            end
            S_RM_RDL: begin
                o_cmd   = CMD_RD_LAST;
                n_state = S_RM_LX;
            end
            S_RM_LX: begin
                o_cmd   = CMD_LD_X;
                n_state = S_TD_START;
            end
            S_TD_START: begin
                if (i_sts.leaf) begin
                    n_state = S_PUT;
                end else begin
                    o_cmd   = CMD_TD_INIT;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd = CMD_SCAN;
                if (i_sts.scan_done) begin
                    n_state = S_TD_DEC;
                end
            end
            S_TD_DEC: begin
                o_cmd = CMD_TD_DEC;
                if (!i_sts.better || i_sts.m_child) begin
                    n_state = S_PUT;
                end else begin
                    n_state = S_TD_RDP;
                end
            end
            S_TD_RDP: begin
                o_cmd   = CMD_RD_PARENT;
                n_state = S_TD_PCMP;
            end
            S_TD_PCMP: begin
                o_cmd   = CMD_TD_PCMP;
                n_state = S_TD_START;
            end
            S_F0: begin
                o_cmd   = CMD_RD_TOP0;
                n_state = S_F1;
            end
            S_F1: begin
                o_cmd   = CMD_CAP0;
                n_state = S_F2;
            end
            S_F2: begin
                o_cmd   = CMD_CAP1;
                n_state = S_F3;
            end
            S_F3: begin
                o_cmd   = CMD_CAP2;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd   = CMD_FIN;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/core/mmhq_dp.sv
module mmhq_dp
    import mmhq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_prio,
    input  logic [15:0] i_burst,
    input  logic        i_ready,
    output t_sts        o_sts,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_removed_id,
    output logic [7:0]  o_removed_prio,
    output logic [15:0] o_removed_burst,
    output logic [15:0] o_min_id,
    output logic [7:0]  o_min_prio,
    output logic [15:0] o_min_burst,
    output logic [15:0] o_max_id,
    output logic [7:0]  o_max_prio,
    output logic [15:0] o_max_burst,
    output logic [9:0]  o_count
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = IW + 3;

    // Heap storage.
    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    t_entry          r_x;
    t_entry          r_m;
    t_entry          r_rm;
    t_entry          r_t0;
    t_entry          r_t1;
    t_entry          r_t2;
    logic [IW-1:0]   r_i;
    logic [IW-1:0]   r_m_idx;
    logic [IW-1:0]   r_pidx;
    logic            r_dir;
    logic            r_m_child;
    logic            r_pv;
    logic            r_pchild;
    logic [2:0]      r_k;
    logic [CW-1:0]   r_cnt;
    logic [15:0]     r_next_id;
    logic [1:0]      r_kind;
    logic [1:0]      r_stat;
    logic            r_ov;

    logic [IW-1:0]   w_rd_addr;
    logic            w_we;
    logic [IW-1:0]   w_wa;
    t_entry          w_wd;
    logic [IW-1:0]   w_parent;
    logic [IW-1:0]   w_gp;
    logic            w_on_min;
    logic [IW:0]     w_j;
    logic [XW-1:0]   w_ie;
    logic [XW-1:0]   w_cand;
    logic            w_cand_ok;
    logic            w_better;
    logic [1:0]      w_sel;
    logic [1:0]      w_fin_sel;
    t_entry          w_sel_e;
    t_entry          w_fin_max;

    assign w_parent = (r_i - IW'(1)) >> 1;
    assign w_gp     = (r_i - IW'(3)) >> 2;
    assign w_ie     = XW'(r_i);

    // Level parity of slot i: min levels have even depth.
    always_comb begin
        w_j      = (IW + 1)'(r_i) + (IW + 1)'(1);
        w_on_min = 1'b1;
        for (int b = 0; b <= IW; b++) begin
            if (w_j[b]) begin
                w_on_min = ((b & 1) == 0);
            end
        end
    end

    // Children and grandchildren of i in comparison order.
    always_comb begin
        case (r_k)
            3'd0:    w_cand = (w_ie << 1) + XW'(1);
            3'd1:    w_cand = (w_ie << 2) + XW'(3);
            3'd2:    w_cand = (w_ie << 2) + XW'(4);
            3'd3:    w_cand = (w_ie << 1) + XW'(2);
            3'd4:    w_cand = (w_ie << 2) + XW'(5);
            default: w_cand = (w_ie << 2) + XW'(6);
        endcase
        w_cand_ok = (r_k < 3'd6) && (w_cand < XW'(r_cnt));
    end

    // Slot to remove: the root for a minimum removal, else the maximum.
    always_comb begin
        if (r_cnt <= CW'(1)) begin
            w_sel = 2'd0;
        end else if (r_cnt == CW'(2)) begin
            w_sel = 2'd1;
        end else begin
            w_sel = (r_t2 > r_t1) ? 2'd2 : 2'd1;
        end
        if (r_kind == KIND_RM_MIN) begin
            w_sel = 2'd0;
        end
        case (w_sel)
            2'd0:    w_sel_e = r_t0;
            2'd1:    w_sel_e = r_t1;
            default: w_sel_e = r_t2;
        endcase
    end

    // Slot of the maximum after the request.
    always_comb begin
        if (r_cnt <= CW'(1)) begin
            w_fin_sel = 2'd0;
        end else if (r_cnt == CW'(2)) begin
            w_fin_sel = 2'd1;
        end else begin
            w_fin_sel = (r_t2 > r_t1) ? 2'd2 : 2'd1;
        end
        case (w_fin_sel)
            2'd0:    w_fin_max = r_t0;
            2'd1:    w_fin_max = r_t1;
            default: w_fin_max = r_t2;
        endcase
    end

    // Comparison result for the step under way.
    always_comb begin
        case (i_cmd)
            CMD_UP_CMP:  w_better = better(r_rdata, r_x, w_on_min);
            CMD_BU_CMP:  w_better = better(r_x, r_rdata, r_dir);
            CMD_TD_DEC:  w_better = better(r_m, r_x, r_dir);
            CMD_TD_PCMP: w_better = better(r_rdata, r_x, r_dir);
            default:     w_better = 1'b0;
        endcase
    end

    // Memory read address.
    always_comb begin
        case (i_cmd)
            CMD_RD_PARENT: w_rd_addr = w_parent;
            CMD_RD_GP:     w_rd_addr = w_gp;
            CMD_RD_LAST:   w_rd_addr = r_cnt[IW-1:0];
            CMD_CAP0:      w_rd_addr = IW'(1);
            CMD_CAP1:      w_rd_addr = IW'(2);
            CMD_SCAN:      w_rd_addr = w_cand[IW-1:0];
            default:       w_rd_addr = '0;
        endcase
    end

    // Memory write port.
    always_comb begin
        w_we = 1'b0;
        w_wa = r_i;
        w_wd = r_rdata;
        case (i_cmd)
            CMD_UP_CMP, CMD_BU_CMP: begin
                w_we = w_better;
            end
            CMD_PUT: begin
                w_we = 1'b1;
                w_wd = r_x;
            end
            CMD_TD_DEC: begin
                w_we = w_better;
                w_wd = r_m;
            end
            CMD_TD_PCMP: begin
                w_we = w_better;
                w_wa = w_parent;
                w_wd = r_x;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_rd_addr];
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
    end

    // Working registers of the heap operations.
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_x    <= '{prio: i_prio, burst: i_burst, id: r_next_id};
                r_kind <= i_kind;
            end
            CMD_DISP: begin
                r_rm <= '0;
                r_i  <= r_cnt[IW-1:0];
                if (r_kind == KIND_INSERT && o_sts.full) begin
                    r_stat <= ST_FULL;
                end else if ((r_kind == KIND_RM_MIN || r_kind == KIND_RM_MAX)
                             && o_sts.empty) begin
                    r_stat <= ST_EMPTY;
                end else begin
                    r_stat <= ST_OK;
                end
            end
            CMD_UP_CMP: begin
                if (w_better) begin
                    r_i   <= w_parent;
                    r_dir <= !w_on_min;
                end else begin
                    r_dir <= w_on_min;
                end
            end
            CMD_BU_CMP: begin
                if (w_better) begin
                    r_i <= w_gp;
                end
            end
            CMD_CAP0: r_t0 <= r_rdata;
            CMD_CAP1: r_t1 <= r_rdata;
            CMD_CAP2: r_t2 <= r_rdata;
            CMD_RM_SEL: begin
                r_rm  <= w_sel_e;
                r_i   <= IW'(w_sel);
                r_dir <= (w_sel == 2'd0);
            end
            CMD_LD_X: r_x <= r_rdata;
            CMD_TD_INIT: r_k <= 3'd0;
            CMD_SCAN: begin
                r_k      <= r_k + 3'd1;
                r_pv     <= w_cand_ok;
                r_pidx   <= w_cand[IW-1:0];
                r_pchild <= (r_k == 3'd0) || (r_k == 3'd3);
                if (r_k == 3'd1) begin
                    r_m       <= r_rdata;
                    r_m_idx   <= r_pidx;
                    r_m_child <= 1'b1;
                end else if (r_k != 3'd0 && r_pv && better(r_rdata, r_m, r_dir)) begin
                    r_m       <= r_rdata;
                    r_m_idx   <= r_pidx;
                    r_m_child <= r_pchild;
                end
            end
            CMD_TD_DEC: begin
                if (w_better) begin
                    r_i <= r_m_idx;
                end
            end
            CMD_TD_PCMP: begin
                if (w_better) begin
                    r_x <= r_rdata;
                end
            end
            default: begin
            end
        endcase
    end

    // Count, id counter and the result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_next_id <= 16'd1;
            r_ov      <= 1'b0;
        end else begin
            if (i_cmd == CMD_FIN) begin
                r_ov <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cmd == CMD_DISP && r_kind == KIND_INSERT && !o_sts.full) begin
                r_cnt     <= r_cnt + CW'(1);
                r_next_id <= r_next_id + 16'd1;
            end
            if (i_cmd == CMD_RM_SEL) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_FIN) begin
            o_status        <= r_stat;
            o_removed_id    <= r_rm.id;
            o_removed_prio  <= r_rm.prio;
            o_removed_burst <= r_rm.burst;
            o_count         <= 10'(r_cnt);
            if (r_cnt == '0) begin
                o_min_id    <= '0;
                o_min_prio  <= '0;
                o_min_burst <= '0;
                o_max_id    <= '0;
                o_max_prio  <= '0;
                o_max_burst <= '0;
            end else begin
                o_min_id    <= r_t0.id;
                o_min_prio  <= r_t0.prio;
                o_min_burst <= r_t0.burst;
                o_max_id    <= w_fin_max.id;
                o_max_prio  <= w_fin_max.prio;
                o_max_burst <= w_fin_max.burst;
            end
        end
    end

    assign o_valid = r_ov;

    // Status toward the controller.
    always_comb begin
        o_sts.kind      = r_kind;
        o_sts.empty     = (r_cnt == '0);
        o_sts.full      = (r_cnt == CW'(CAPACITY));
        o_sts.i_zero    = (r_i == '0);
        o_sts.i_lt3     = (r_i < IW'(3));
        o_sts.leaf      = ((w_ie << 1) + XW'(1)) >= XW'(r_cnt);
        o_sts.better    = w_better;
        o_sts.m_child   = r_m_child;
        o_sts.s_inner   = (CW'(w_sel) < (r_cnt - CW'(1)));
        o_sts.scan_done = (r_k == 3'd6);
        o_sts.out_busy  = r_ov && !i_ready;
    end

endmodule

>>> rtl/core/min_max_heap_queue.sv
// Double-ended priority queue kept as a min-max heap in one on-chip memory.
// Request channel: i_valid/o_ready carry i_kind (insert, remove minimum,
// remove maximum), i_prio and i_burst. Result channel: o_valid/i_ready
// carry the status, the removed entry, the current minimum and maximum and
// the entry count. Every request gives exactly one result.
// Requests are served one at a time. The memory has one read and one write
// port with a registered read. An insert compares with its parent and then
// climbs one grandparent level per step; a removal trickles down, each step
// moving two levels and scanning up to six children and grandchildren
// through the single read port.
// Reset empties the queue at once (no clearing pass) and restarts arrival
// ids at one. A finished result waits in the output register while the
// receiver stalls; the next request is taken meanwhile but its result is
// held back until the previous one has been taken.
module min_max_heap_queue
    import mmhq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_prio,
    input  logic [15:0] i_burst,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_removed_id,
    output logic [7:0]  o_removed_prio,
    output logic [15:0] o_removed_burst,
    output logic [15:0] o_min_id,
    output logic [7:0]  o_min_prio,
    output logic [15:0] o_min_burst,
    output logic [15:0] o_max_id,
    output logic [7:0]  o_max_prio,
    output logic [15:0] o_max_burst,
    output logic [9:0]  o_count
);

    t_cmd w_cmd;
    t_sts w_sts;

    mmhq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    mmhq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_kind          (i_kind),
        .i_prio          (i_prio),
        .i_burst         (i_burst),
        .i_ready         (i_ready),
        .o_sts           (w_sts),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_removed_id    (o_removed_id),
        .o_removed_prio  (o_removed_prio),
        .o_removed_burst (o_removed_burst),
        .o_min_id        (o_min_id),
        .o_min_prio      (o_min_prio),
        .o_min_burst     (o_min_burst),
        .o_max_id        (o_max_id),
        .o_max_prio      (o_max_prio),
        .o_max_burst     (o_max_burst),
        .o_count         (o_count)
    );

    // A refused removal reports no entry.
    a_empty_nothing_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |->
            o_removed_prio == 8'd0 && o_removed_burst == 16'd0 && o_removed_id == 16'd0)
        else $error("removal from empty queue reported an entry");

    // The reported minimum never ranks above the reported maximum.
    a_min_not_above_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            {o_min_prio, o_min_burst, o_min_id} <= {o_max_prio, o_max_burst, o_max_id})
        else $error("minimum ranks above maximum");

    // A new request is only taken with no result being assembled.
    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> w_cmd == CMD_NOP || w_cmd == CMD_LOAD)
        else $error("request taken while busy");

endmodule

>>> sim/min_max_heap_queue_tb.sv
module min_max_heap_queue_tb;
    import mmhq_pkg::*;

    localparam int DEPTH       = 512;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [1:0] KIND_NOP = 2'd3;

    // One request as queued for the driver.
    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  prio;
        logic [15:0] burst;
        bit          drain;
    } t_request;

    // One expected result.
    typedef struct packed {
        logic [1:0] status;
        t_entry     rem;
        t_entry     lo;
        t_entry     hi;
        logic [9:0] count;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_kind = KIND_INSERT;
    logic [7:0]  i_prio = '0;
    logic [15:0] i_burst = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_removed_id;
    logic [7:0]  o_removed_prio;
    logic [15:0] o_removed_burst;
    logic [15:0] o_min_id;
    logic [7:0]  o_min_prio;
    logic [15:0] o_min_burst;
    logic [15:0] o_max_id;
    logic [7:0]  o_max_prio;
    logic [15:0] o_max_burst;
    logic [9:0]  o_count;

    min_max_heap_queue DUT (.*);

    t_request pending_q[$];
    t_outcome outcome_q[$];
    t_request cur_req;

    // Mirror of the heap contents.
    t_entry      heap_mem[DEPTH];
    int          heap_size = 0;
    logic [15:0] arrival_id = 16'd1;

    int tx_gap = 0;
    int rx_gap = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_full = 0;
    int n_empty = 0;
    int n_bad = 0;
    int cycles = 0;

    // Clock.
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Heap arithmetic used by the predictor.
    function automatic bit is_min_level(int idx);
        int j;
        int lvl;
        j = idx + 1;
        lvl = 0;
        while (j > 1) begin
            j = j >> 1;
            lvl++;
        end
        return (lvl % 2) == 0;
    endfunction

    function automatic bit ranks_first(t_entry a, t_entry b, bit mn);
        return mn ? (a < b) : (a > b);
    endfunction

    function automatic void swap_entries(int a, int b);
        t_entry t;
        t = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = t;
    endfunction

    function automatic void climb_grandparents(int idx, bit mn);
        int g;
        while (idx >= 3) begin
            g = (((idx - 1) >> 1) - 1) >> 1;
            if (!ranks_first(heap_mem[idx], heap_mem[g], mn)) break;
            swap_entries(idx, g);
            idx = g;
        end
    endfunction

    function automatic void sift_up(int idx);
        int p;
        bit mn;
        if (idx == 0) return;
        p = (idx - 1) >> 1;
        mn = is_min_level(idx);
        if (ranks_first(heap_mem[p], heap_mem[idx], mn)) begin
            swap_entries(idx, p);
            climb_grandparents(p, !mn);
        end else begin
            climb_grandparents(idx, mn);
        end
    endfunction

    function automatic void sift_down(int idx);
        bit mn;
        int first;
        int m;
        int p;
        mn = is_min_level(idx);
        forever begin
            first = 2 * idx + 1;
            if (first >= heap_size) return;
            m = first;
            for (int c = first; c < first + 2 && c < heap_size; c++) begin
                if (ranks_first(heap_mem[c], heap_mem[m], mn)) m = c;
                for (int k = 2 * c + 1; k < 2 * c + 3 && k < heap_size; k++)
                    if (ranks_first(heap_mem[k], heap_mem[m], mn)) m = k;
            end
            if (!ranks_first(heap_mem[m], heap_mem[idx], mn)) return;
            swap_entries(m, idx);
            if (m < first + 2) return;
            p = (m - 1) >> 1;
            if (ranks_first(heap_mem[p], heap_mem[m], mn)) swap_entries(m, p);
            idx = m;
        end
    endfunction

    function automatic int largest_slot();
        if (heap_size <= 1) return 0;
        if (heap_size == 2) return 1;
        return (heap_mem[2] > heap_mem[1]) ? 2 : 1;
    endfunction

    // Apply one accepted request to the mirror and queue its result.
    function automatic void predict_heap_result(t_request r);
        t_outcome o;
        int s;
        o = '0;
        if (r.kind == KIND_INSERT) begin
            if (heap_size >= DEPTH) begin
                o.status = ST_FULL;
                n_full++;
            end else begin
                heap_mem[heap_size] = '{prio: r.prio, burst: r.burst, id: arrival_id};
                arrival_id = arrival_id + 16'd1;
                heap_size++;
                sift_up(heap_size - 1);
            end
        end else if (r.kind == KIND_RM_MIN || r.kind == KIND_RM_MAX) begin
            if (heap_size == 0) begin
                o.status = ST_EMPTY;
                n_empty++;
            end else begin
                s = (r.kind == KIND_RM_MIN) ? 0 : largest_slot();
                o.rem = heap_mem[s];
                heap_size--;
                if (s < heap_size) begin
                    heap_mem[s] = heap_mem[heap_size];
                    sift_down(s);
                end
            end
        end
        if (heap_size != 0) begin
            o.lo = heap_mem[0];
            o.hi = heap_mem[largest_slot()];
        end
        o.count = heap_size[9:0];
        outcome_q.push_back(o);
    endfunction

    function automatic int draw_gap();
        if ((n_sent / 64) % 3 == 0) return 0;
        return $urandom_range(0, 9);
    endfunction

    function automatic void add_request(logic [1:0] k, logic [7:0] p, logic [15:0] b,
                                        bit d = 0);
        pending_q.push_back('{kind: k, prio: p, burst: b, drain: d});
    endfunction

    function automatic void add_random(bit d = 0);
        int sel;
        logic [1:0] k;
        logic [7:0] p;
        logic [15:0] b;
        sel = $urandom_range(0, 19);
        k = (sel < 10) ? KIND_INSERT : (sel < 15) ? KIND_RM_MIN :
            (sel < 19) ? KIND_RM_MAX : KIND_NOP;
        p = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3));
        b = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 3));
        add_request(k, p, b, d);
    endfunction

    // Count a mismatch on one field; only the first ten mismatches are reported.
    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            n_bad++;
            if (n_bad <= 10)
                $display("mismatch on result %0d field %s: expected %0h, got %0h",
                         n_checked, name, want, got);
        end
    endfunction

    // Driver: presents queued requests with random gaps.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_heap_result(cur_req);
                n_sent++;
                tx_gap = draw_gap();
            end
            if (!i_valid || o_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (pending_q.size() > 0 &&
                             (!pending_q[0].drain || outcome_q.size() == 0)) begin
                    cur_req = pending_q.pop_front();
                    i_kind  <= cur_req.kind;
                    i_prio  <= cur_req.prio;
                    i_burst <= cur_req.burst;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes results with random stalls and checks them.
    always @(posedge i_clk) begin
        t_outcome w;
        bit rdy;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (outcome_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) $display("result with no request outstanding");
                end else begin
                    w = outcome_q.pop_front();
                    check_field("status", w.status, o_status);
                    check_field("removed_id", w.rem.id, o_removed_id);
                    check_field("removed_prio", w.rem.prio, o_removed_prio);
                    check_field("removed_burst", w.rem.burst, o_removed_burst);
                    check_field("min_id", w.lo.id, o_min_id);
                    check_field("min_prio", w.lo.prio, o_min_prio);
                    check_field("min_burst", w.lo.burst, o_min_burst);
                    check_field("max_id", w.hi.id, o_max_id);
                    check_field("max_prio", w.hi.prio, o_max_prio);
                    check_field("max_burst", w.hi.burst, o_max_burst);
                    check_field("count", w.count, o_count);
                    n_checked++;
                end
                rx_gap = draw_gap();
            end
            if (rx_gap > 0) begin
                rx_gap--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            i_ready <= rdy;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        // Empty removals, idle kind, extreme and tied entries.
        add_request(KIND_RM_MIN, 8'd0, 16'd0);
        add_request(KIND_RM_MAX, 8'd0, 16'd0);
        add_request(KIND_NOP, 8'hFF, 16'hFFFF);
        add_request(KIND_INSERT, 8'd0, 16'd0);
        add_request(KIND_INSERT, 8'hFF, 16'hFFFF);
        add_request(KIND_INSERT, 8'd1, 16'd1);
        add_request(KIND_INSERT, 8'h80, 16'h8000);
        add_request(KIND_INSERT, 8'h80, 16'h8000);
        add_request(KIND_INSERT, 8'h7F, 16'h7FFF);
        add_request(KIND_NOP, 8'd0, 16'd0);
        add_request(KIND_RM_MAX, 8'd0, 16'd0);
        add_request(KIND_RM_MIN, 8'd0, 16'd0);
        add_request(KIND_RM_MAX, 8'd0, 16'd0);
        add_request(KIND_INSERT, 8'h80, 16'h8000);
        add_request(KIND_RM_MAX, 8'd0, 16'd0);
        add_request(KIND_RM_MAX, 8'd0, 16'd0);
        add_request(KIND_RM_MIN, 8'd0, 16'd0);
        add_request(KIND_RM_MIN, 8'd0, 16'd0);
        add_request(KIND_RM_MAX, 8'd0, 16'd0);
        add_request(KIND_RM_MIN, 8'd0, 16'd0);
        // Mixed traffic.
        for (int n = 0; n < 50; n++) add_random();
        // Fill to capacity and beyond, after the pipeline has drained.
        for (int n = 0; n < 520; n++)
            add_request(KIND_INSERT, 8'($urandom_range(0, 255)),
                        16'($urandom_range(0, 65535)), n == 0);
        for (int n = 0; n < 30; n++)
            add_request(n % 2 ? KIND_RM_MAX : KIND_RM_MIN, 8'd0, 16'd0);
        for (int n = 0; n < 30; n++) add_random(n == 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_q.size() == 0 && !i_valid);
        wait (outcome_q.size() == 0);
        repeat (200) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked, %0d mismatches",
                 n_sent, n_checked, n_bad);
        $display("full rejections %0d, empty removals %0d", n_full, n_empty);
        if (n_bad == 0 && outcome_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> min_max_heap_queue.f
rtl/core/mmhq_pkg.sv
rtl/core/mmhq_ctrl.sv
rtl/core/mmhq_dp.sv
rtl/core/min_max_heap_queue.sv
sim/min_max_heap_queue_tb.sv
